FILE: src/mi3_pkg.sv
package mi3_pkg;

   localparam int ELEM_W = 32;
   localparam int COF_W  = 64;
   localparam int DET_W  = 97;
   localparam int REM_W  = 130;
   localparam int QUO_W  = 32;
   localparam int N_ELEM = 9;
   localparam int N_TERM = 3;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_type;
   typedef logic signed [COF_W-1:0] cof_type;
   typedef logic [N_ELEM-1:0][COF_W-1:0] adj_type;
   typedef logic signed [DET_W-1:0] det_type;

   typedef struct packed {
      adj_type adj;
      logic [N_TERM-1:0][ELEM_W-1:0] col;
   } cofout_type;

   typedef struct packed {
      adj_type adj;
      det_type det;
   } adjdet_type;

   // Element indexes of the two products p*q - r*s that form each adjugate entry.
   localparam int COF_SRC [0:N_ELEM-1][0:3] = '{
      '{4, 8, 5, 7},
      '{2, 7, 1, 8},
      '{1, 5, 2, 4},
      '{5, 6, 3, 8},
      '{0, 8, 2, 6},
      '{2, 3, 0, 5},
      '{3, 7, 4, 6},
      '{1, 6, 0, 7},
      '{0, 4, 1, 3}
   };

endpackage

FILE: src/mi3_cofactor.sv
module mi3_cofactor (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mi3_pkg::mat_type       in_mat,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mi3_pkg::cofout_type    out_cof
);

   mi3_pkg::cof_type prod_ff [mi3_pkg::N_ELEM][2];
   mi3_pkg::cof_type prod_in [mi3_pkg::N_ELEM][2];
   logic [mi3_pkg::N_TERM-1:0][mi3_pkg::ELEM_W-1:0] col_ff, col_in;
   mi3_pkg::cofout_type cof_ff, cof_in;
   logic v1_ff, v2_ff;
   logic rdy1, rdy2;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
         prod_in[k][0] = $signed(in_mat[mi3_pkg::COF_SRC[k][0]])
                       * $signed(in_mat[mi3_pkg::COF_SRC[k][1]]);
         prod_in[k][1] = $signed(in_mat[mi3_pkg::COF_SRC[k][2]])
                       * $signed(in_mat[mi3_pkg::COF_SRC[k][3]]);
      end
      col_in[0] = in_mat[0];
      col_in[1] = in_mat[3];
      col_in[2] = in_mat[6];
   end

   always_comb begin
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
         cof_in.adj[k] = prod_ff[k][0] - prod_ff[k][1];
      end
      cof_in.col = col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod_ff <= prod_in;
         col_ff  <= col_in;
      end
      if (rdy2) cof_ff <= cof_in;
   end

   assign out_valid = v2_ff;
   assign out_cof   = cof_ff;

endmodule

FILE: src/mi3_det.sv
module mi3_det (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mi3_pkg::cofout_type    in_cof,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mi3_pkg::adjdet_type    out_ad
);

   typedef logic signed [mi3_pkg::COF_W:0]   lo_type;
   typedef logic signed [mi3_pkg::COF_W-1:0] hi_type;

   lo_type pl_ff [mi3_pkg::N_TERM];
   lo_type pl_in [mi3_pkg::N_TERM];
   hi_type ph_ff [mi3_pkg::N_TERM];
   hi_type ph_in [mi3_pkg::N_TERM];
   mi3_pkg::det_type t_ff [mi3_pkg::N_TERM];
   mi3_pkg::det_type t_in [mi3_pkg::N_TERM];
   mi3_pkg::adj_type adj1_ff, adj2_ff;
   mi3_pkg::adjdet_type ad_ff, ad_in;
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      for (int k = 0; k < mi3_pkg::N_TERM; k++) begin
         pl_in[k] = $signed(in_cof.col[k]) * $signed({1'b0, in_cof.adj[k][31:0]});
         ph_in[k] = $signed(in_cof.col[k]) * $signed(in_cof.adj[k][63:32]);
      end
   end

   always_comb begin
      for (int k = 0; k < mi3_pkg::N_TERM; k++) begin
         t_in[k] = (mi3_pkg::det_type'(ph_ff[k]) <<< 32) + mi3_pkg::det_type'(pl_ff[k]);
      end
   end

   always_comb begin
      ad_in.adj = adj2_ff;
      ad_in.det = t_ff[0] + t_ff[1] + t_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         adj1_ff <= in_cof.adj;
      end
      if (rdy2) begin
         t_ff    <= t_in;
         adj2_ff <= adj1_ff;
      end
      if (rdy3) ad_ff <= ad_in;
   end

   assign out_valid = v3_ff;
   assign out_ad    = ad_ff;

endmodule

FILE: src/mi3_div.sv
module mi3_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mi3_pkg::adjdet_type    in_ad,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mi3_pkg::mat_type       out_b,
   output logic                   out_sing
);

   localparam int NS = mi3_pkg::QUO_W + 2;

   typedef logic [mi3_pkg::REM_W-1:0] rem_type;

   typedef struct packed {
      rem_type                     rem;
      logic [mi3_pkg::QUO_W-1:0]   quo;
      logic                        neg;
      logic                        ovf;
   } lane_type;

   typedef struct packed {
      lane_type [mi3_pkg::N_ELEM-1:0] lane;
      rem_type                        dmag;
      logic                           sing;
   } div_type;

   div_type st_ff [0:NS-1];
   div_type st_in [0:NS-1];
   logic [NS-1:0] v_ff;
   logic [NS:0]   rdy;
   mi3_pkg::mat_type b_ff, b_in;
   logic sing_ff;
   logic vo_ff;

   assign rdy[NS]  = !vo_ff || out_ready;
   assign in_ready = rdy[0];

   always_comb begin
      logic                      dneg;
      mi3_pkg::det_type          mag;
      logic [mi3_pkg::COF_W-1:0] cm;
      logic                      cn;
      st_in[0].sing = (in_ad.det == '0);
      dneg = in_ad.det[mi3_pkg::DET_W-1];
      mag  = dneg ? -in_ad.det : in_ad.det;
      if (st_in[0].sing) begin
         st_in[0].dmag = rem_type'(1) << (3 * FRAC_BITS);
      end else begin
         st_in[0].dmag = {{(mi3_pkg::REM_W - mi3_pkg::DET_W){1'b0}}, mag};
      end
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
         cn = in_ad.adj[k][mi3_pkg::COF_W-1];
         cm = cn ? (mi3_pkg::COF_W'(0) - in_ad.adj[k]) : in_ad.adj[k];
         st_in[0].lane[k].rem = {{(mi3_pkg::REM_W - mi3_pkg::COF_W){1'b0}}, cm}
                                << (2 * FRAC_BITS);
         st_in[0].lane[k].quo = '0;
         st_in[0].lane[k].neg = cn ^ (dneg && !st_in[0].sing);
         st_in[0].lane[k].ovf = 1'b0;
      end
   end

   always_comb begin
      st_in[1] = st_ff[0];
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
         st_in[1].lane[k].ovf = st_ff[0].lane[k].rem >= (st_ff[0].dmag << mi3_pkg::QUO_W);
      end
   end

   for (genvar s = 0; s < mi3_pkg::QUO_W; s++) begin : g_step
      localparam int B = mi3_pkg::QUO_W - 1 - s;
      always_comb begin
         rem_type sh;
         sh = st_ff[s+1].dmag << B;
         st_in[s+2] = st_ff[s+1];
         for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
            if (st_ff[s+1].lane[k].rem >= sh) begin
               st_in[s+2].lane[k].rem    = st_ff[s+1].lane[k].rem - sh;
               st_in[s+2].lane[k].quo[B] = 1'b1;
            end
         end
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      assign rdy[s] = !v_ff[s] || rdy[s+1];
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= (s == 0) ? in_valid : v_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (rdy[s]) st_ff[s] <= st_in[s];
      end
   end

   always_comb begin
      lane_type ln;
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
         ln = st_ff[NS-1].lane[k];
         if (!ln.neg) begin
            if (ln.ovf || ln.quo[mi3_pkg::QUO_W-1]) b_in[k] = 32'h7FFF_FFFF;
            else b_in[k] = ln.quo;
         end else begin
            if (ln.ovf || (ln.quo > 32'h8000_0000)) b_in[k] = 32'h8000_0000;
            else b_in[k] = 32'd0 - ln.quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (rdy[NS]) begin
         vo_ff <= v_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NS]) begin
         b_ff    <= b_in;
         sing_ff <= st_ff[NS-1].sing;
      end
   end

   assign out_valid = vo_ff;
   assign out_b     = b_ff;
   assign out_sing  = sing_ff;

`ifndef SYNTHESIS
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] |-> st_ff[1].dmag != '0)
      else $error("divisor is zero in the divider");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && !st_ff[NS-1].lane[0].ovf |->
      st_ff[NS-1].lane[0].rem < st_ff[NS-1].dmag)
      else $error("final remainder is not below the divisor");
`endif

endmodule

FILE: src/matrix3_inverse.sv
// 3x3 matrix inverse in signed fixed point with FRAC_BITS fractional bits.
// The request channel (req_valid, req_ready, req_a00 .. req_a22) takes one
// matrix per item. The response channel (rsp_valid, rsp_ready, rsp_b00 ..
// rsp_b22, rsp_singular) returns the inverse, truncated toward zero and
// saturated to 32 bits. A matrix with a zero determinant returns its adjugate
// shifted right by FRAC_BITS with rsp_singular set.
// The cofactor products, the determinant and the divider are each registered
// pipelines; the divider's restoring quotient takes one bit per stage across
// nine parallel lanes. Throughput is one item per cycle while rsp_ready does
// not stall. Every stage carries its own valid bit and
// advances when it is empty or the stage after it moves, so a stall on
// rsp_ready holds the output item and lets bubbles in the pipeline close up;
// req_ready drops only when every stage holds an item.
// Reset empties the pipeline and clears rsp_valid; no other state is kept
// between items.
module matrix3_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_a00,
   input  logic signed [31:0] req_a01,
   input  logic signed [31:0] req_a02,
   input  logic signed [31:0] req_a10,
   input  logic signed [31:0] req_a11,
   input  logic signed [31:0] req_a12,
   input  logic signed [31:0] req_a20,
   input  logic signed [31:0] req_a21,
   input  logic signed [31:0] req_a22,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_b00,
   output logic signed [31:0] rsp_b01,
   output logic signed [31:0] rsp_b02,
   output logic signed [31:0] rsp_b10,
   output logic signed [31:0] rsp_b11,
   output logic signed [31:0] rsp_b12,
   output logic signed [31:0] rsp_b20,
   output logic signed [31:0] rsp_b21,
   output logic signed [31:0] rsp_b22,
   output logic               rsp_singular
);

   mi3_pkg::mat_type    mat;
   mi3_pkg::mat_type    inv;
   mi3_pkg::cofout_type cof;
   mi3_pkg::adjdet_type ad;
   logic cof_valid, cof_ready;
   logic ad_valid, ad_ready;

   assign mat[0] = req_a00;
   assign mat[1] = req_a01;
   assign mat[2] = req_a02;
   assign mat[3] = req_a10;
   assign mat[4] = req_a11;
   assign mat[5] = req_a12;
   assign mat[6] = req_a20;
   assign mat[7] = req_a21;
   assign mat[8] = req_a22;

   mi3_cofactor u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_mat    (mat),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_cof   (cof)
   );

   mi3_det u_det (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_cof    (cof),
      .out_valid (ad_valid),
      .out_ready (ad_ready),
      .out_ad    (ad)
   );

   mi3_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ad_valid),
      .in_ready  (ad_ready),
      .in_ad     (ad),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_b     (inv),
      .out_sing  (rsp_singular)
   );

   assign rsp_b00 = inv[0];
   assign rsp_b01 = inv[1];
   assign rsp_b02 = inv[2];
   assign rsp_b10 = inv[3];
   assign rsp_b11 = inv[4];
   assign rsp_b12 = inv[5];
   assign rsp_b20 = inv[6];
   assign rsp_b21 = inv[7];
   assign rsp_b22 = inv[8];

`ifndef SYNTHESIS
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled while the output stage is empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule
